// File: rtl/tcis_pkg.sv
// Package with shared types, constants and the glyph table for the toy CPU step core.
package tcis_pkg;

    localparam int MemWords  = 65536;
    localparam int MemAw     = $clog2(MemWords);
    localparam int NumRegs   = 8;
    localparam int RegAw     = 3;
    localparam int GlyphCount = 92;

    localparam logic [15:0] StartReset = 16'h1FE1;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_EXEC  = 2'd2;

    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_LOAD = 8'h01;
    localparam logic [7:0] OP_STOR = 8'h02;
    localparam logic [7:0] OP_IMM  = 8'h03;
    localparam logic [7:0] OP_ADDM = 8'h04;
    localparam logic [7:0] OP_ADDI = 8'h05;
    localparam logic [7:0] OP_SUBM = 8'h06;
    localparam logic [7:0] OP_SUBI = 8'h07;
    localparam logic [7:0] OP_CMP  = 8'h08;
    localparam logic [7:0] OP_AND  = 8'h09;
    localparam logic [7:0] OP_OR   = 8'h0A;
    localparam logic [7:0] OP_XOR  = 8'h0B;
    localparam logic [7:0] OP_NOT  = 8'h0C;
    localparam logic [7:0] OP_SHL  = 8'h0D;
    localparam logic [7:0] OP_SHR  = 8'h0E;
    localparam logic [7:0] OP_JMP  = 8'h0F;
    localparam logic [7:0] OP_JZ   = 8'h10;
    localparam logic [7:0] OP_JNZ  = 8'h11;
    localparam logic [7:0] OP_CHAR = 8'h20;
    localparam logic [7:0] OP_DRAW = 8'hFE;
    localparam logic [7:0] OP_HALT = 8'hFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [15:0] data;
    } t_in;

    typedef struct packed {
        logic [15:0] read_data;
        logic [15:0] next_ip;
        logic        zero_flag;
        logic        halted;
        logic        draw_request;
        logic        bad_opcode;
    } t_out;

    // Memory select for the datapath address mux.
    localparam logic [2:0] MA_IN  = 3'd0;
    localparam logic [2:0] MA_IP  = 3'd1;
    localparam logic [2:0] MA_IP1 = 3'd2;
    localparam logic [2:0] MA_OP  = 3'd3;
    localparam logic [2:0] MA_CH  = 3'd4;

    typedef struct packed {
        logic       start;     // take the input beat
        logic       mem_rd;
        logic       mem_wr;
        logic [2:0] addr_sel;
        logic       ld_w0;
        logic       ld_op;
        logic       ld_src;
        logic       exec;      // commit the instruction
        logic       ch_init;
        logic       ch_step;   // write one glyph word
        logic       done;      // capture result
    } t_cmd;

    typedef struct packed {
        logic [7:0] opcode;
        logic       ch_valid;
        logic       ch_last;
        logic       halted;
    } t_sts;

    function automatic logic [15:0] glyph_row(input logic [7:0] g, input logic [1:0] r);
        logic [15:0] t [0:GlyphCount*4-1];
        t = '{
        16'h386C,16'hC6C6,16'hFEC6,16'hC600,16'hFCC6,16'hC6FC,16'hC6C6,16'hFC00,
        16'h3C66,16'hC0C0,16'hC066,16'h3C00,16'hF8CC,16'hC6C6,16'hC6CC,16'hF800,
        16'hFEC0,16'hC0FC,16'hC0C0,16'hFE00,16'hFEC0,16'hC0FC,16'hC0C0,16'hC000,
        16'h3E60,16'hC0CE,16'hC666,16'h3E00,16'hC6C6,16'hC6FE,16'hC6C6,16'hC600,
        16'h7E18,16'h1818,16'h1818,16'h7E00,16'h0606,16'h0606,16'h0606,16'h7C00,
        16'hC6CC,16'hD8F0,16'hF8DC,16'hCE00,16'h6060,16'h6060,16'h6060,16'h7E00,
        16'hC6EE,16'hFEFE,16'hD6C6,16'hC600,16'hC6E6,16'hF6FE,16'hDECE,16'hC600,
        16'h7CC6,16'hC6C6,16'hC6C6,16'h7C00,16'hFCC6,16'hC6C6,16'hFCC0,16'hC000,
        16'h7CC6,16'hC6C6,16'hDECC,16'h7A00,16'hFCC6,16'hC6CE,16'hF8DC,16'hCE00,
        16'h78CC,16'hC07C,16'h06C6,16'h7C00,16'h7E18,16'h1818,16'h1818,16'h1800,
        16'hC6C6,16'hC6C6,16'hC6C6,16'h7C00,16'hC6C6,16'hC6EE,16'h7C38,16'h1000,
        16'hC6C6,16'hD6FE,16'hFEEE,16'hC600,16'hC6EE,16'h7C38,16'h7CEE,16'hC600,
        16'h6666,16'h663C,16'h1818,16'h1800,16'hFE0E,16'h1C38,16'h70E0,16'hFE00,
        16'h0030,16'h3000,16'h3030,16'h0000,16'h0030,16'h3000,16'h3030,16'h6000,
        16'h0018,16'h3060,16'h3018,16'h0000,16'h0030,16'h180C,16'h1830,16'h0000,
        16'h3030,16'h3000,16'h0000,16'h0000,16'h6C6C,16'h6C00,16'h0000,16'h0000,
        16'h0000,16'h7C06,16'h7EC6,16'h7E00,16'hC0C0,16'hFCC6,16'hC6C6,16'h7C00,
        16'h0000,16'h7EC0,16'hC0C0,16'h7E00,16'h0606,16'h7EC6,16'hC6C6,16'h7E00,
        16'h0000,16'h7CC6,16'hFEC0,16'h7C00,16'h0E18,16'h7E18,16'h1818,16'h1800,
        16'h0000,16'h7EC6,16'hC67E,16'h067C,16'hC0C0,16'hFCC6,16'hC6C6,16'hC600,
        16'h1800,16'h3818,16'h1818,16'h7E00,16'h0C00,16'h1C0C,16'h0C0C,16'h0C78,
        16'hC0C0,16'hCEFC,16'hF8DC,16'hCE00,16'h3818,16'h1818,16'h1818,16'h7E00,
        16'h0000,16'hFCB6,16'hB6B6,16'hB600,16'h0000,16'hFCC6,16'hC6C6,16'hC600,
        16'h0000,16'h7CC6,16'hC6C6,16'h7C00,16'h0000,16'hFCC6,16'hC6FC,16'hC0C0,
        16'h0000,16'h7EC6,16'hC67E,16'h0606,16'h0000,16'hCE70,16'h6060,16'h6000,
        16'h0000,16'h7CC0,16'h7C06,16'hFC00,16'h1818,16'h7E18,16'h1818,16'h1800,
        16'h0000,16'hC6C6,16'hC6C6,16'h7E00,16'h0000,16'h6666,16'h663C,16'h1800,
        16'h0000,16'hB6B6,16'hB6B6,16'h7E00,16'h0000,16'hC6FE,16'h38FE,16'hC600,
        16'h0000,16'hC6C6,16'hC67E,16'h067C,16'h0000,16'hFE1C,16'h3870,16'hFE00,
        16'h3838,16'h3830,16'h3000,16'h3000,16'h7C82,16'hBAAA,16'hBE80,16'h7C00,
        16'h6CFE,16'h6C6C,16'h6CFE,16'h6C00,16'h107C,16'hD07C,16'h16FC,16'h1000,
        16'h62A4,16'hC810,16'h264A,16'h8C00,16'h1028,16'h4400,16'h0000,16'h0000,
        16'h70D8,16'hD870,16'hDACC,16'h7E00,16'h006C,16'h38FE,16'h386C,16'h0000,
        16'h0C18,16'h3030,16'h3018,16'h0C00,16'h6030,16'h1818,16'h1830,16'h6000,
        16'h0018,16'h187E,16'h1818,16'h0000,16'h0000,16'h007E,16'h0000,16'h0000,
        16'h0000,16'h0000,16'h0000,16'h00FE,16'h0000,16'h0000,16'h0030,16'h3060,
        16'h0000,16'h0000,16'h0030,16'h3000,16'h0204,16'h0810,16'h2040,16'h8000,
        16'h7CC6,16'hCED6,16'hE6C6,16'h7C00,16'h1838,16'h1818,16'h1818,16'h7E00,
        16'h7CC6,16'h0E3C,16'h78E0,16'hFE00,16'h7E0C,16'h183C,16'h06C6,16'h7C00,
        16'h1C3C,16'h6CCC,16'hFE0C,16'h0C00,16'hFCC0,16'hFC06,16'h06C6,16'h7C00,
        16'h3C60,16'hC0FC,16'hC6C6,16'h7C00,16'hFEC6,16'h0C18,16'h3030,16'h3000,
        16'h78C4,16'hE478,16'h9E86,16'h7C00,16'h7CC6,16'hC67E,16'h060C,16'h7800,
        16'h7CFE,16'hC60C,16'h3800,16'h3800,16'h0C18,16'h1830,16'h1818,16'h0C00,
        16'h1818,16'h1818,16'h1818,16'h1800,16'h6030,16'h3018,16'h3030,16'h6000,
        16'h3C30,16'h3030,16'h3030,16'h3C00,16'h8040,16'h2010,16'h0804,16'h0200,
        16'h7818,16'h1818,16'h1818,16'h7800,16'h0000,16'h7E00,16'h7E00,16'h0000};
        if (g < 8'(GlyphCount)) begin
            return t[{g[6:0], r}];
        end
        return 16'h0000;
    endfunction

endpackage

// File: rtl/tcis_ctrl.sv
// Sequencer that steps the datapath through one item.
module tcis_ctrl import tcis_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  logic [1:0] i_kind,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_W0   = 3'd1;
    localparam logic [2:0] S_OP   = 3'd2;
    localparam logic [2:0] S_SRC  = 3'd3;
    localparam logic [2:0] S_EXE  = 3'd4;
    localparam logic [2:0] S_CHR  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state, n_state;
    logic r_out_valid, n_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.start    = 1'b1;
                    o_cmd.addr_sel = MA_IN;
                    if (i_kind == KIND_WRITE) begin
                        o_cmd.mem_wr = 1'b1;
                        n_state      = S_FIN;
                    end else if (i_kind == KIND_READ) begin
                        o_cmd.mem_rd = 1'b1;
                        n_state      = S_FIN;
                    end else if (i_kind == KIND_EXEC && !i_sts.halted) begin
                        o_cmd.addr_sel = MA_IP;
                        o_cmd.mem_rd   = 1'b1;
                        n_state        = S_W0;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_W0: begin
                o_cmd.ld_w0    = 1'b1;
                o_cmd.addr_sel = MA_IP1;
                o_cmd.mem_rd   = 1'b1;
                n_state        = S_OP;
            end
            S_OP: begin
                o_cmd.ld_op    = 1'b1;
                n_state        = S_SRC;
            end
            S_SRC: begin
                o_cmd.addr_sel = MA_OP;
                o_cmd.mem_rd   = 1'b1;
                n_state        = S_EXE;
            end
            S_EXE: begin
                o_cmd.ld_src   = 1'b1;
                o_cmd.exec     = 1'b1;
                o_cmd.addr_sel = MA_OP;
                if (i_sts.opcode == OP_CHAR && i_sts.ch_valid) begin
                    o_cmd.ch_init = 1'b1;
                    n_state       = S_CHR;
                end else begin
                    o_cmd.mem_wr = (i_sts.opcode == OP_STOR);
                    n_state      = S_FIN;
                end
            end
            S_CHR: begin
                o_cmd.ch_step  = 1'b1;
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = MA_CH;
                if (i_sts.ch_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.done  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/tcis_dp.sv
// Datapath with memory, register file, flags, ALU and glyph writer.
module tcis_dp import tcis_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  t_in         i_in,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output t_out        o_out
);

    logic [15:0] mem [0:MemWords-1];
    logic [15:0] r_rdata;
    logic [15:0] regs [0:NumRegs-1];
    logic [15:0] r_ip;
    logic        r_zero, r_halt, r_draw, r_bad;
    logic [15:0] r_w0, r_op;
    logic [1:0]  r_kind;
    logic [15:0] r_chreg, r_chdst;
    logic [3:0]  r_chcnt;
    t_out        r_out;

    logic [7:0]  opc, sel;
    logic [6:0]  rnum;
    logic [1:0]  part;
    logic [15:0] m, reg_v, src, res, nv, maddr, wdata, line, pix;
    logic [3:0]  nib, fg, bg;
    logic        wr_reg, reg_ok;

    assign opc  = r_w0[15:8];
    assign sel  = r_w0[7:0];
    // The select divided by three through a reciprocal multiply, exact for every byte value.
    assign rnum = 7'((16'(sel) * 16'd171) >> 9);
    assign part = 2'(sel - 8'(rnum) * 8'd3);
    assign m    = (part == 2'd0) ? 16'hFFFF : ((part == 2'd1) ? 16'hFF00 : 16'h00FF);
    assign reg_ok = rnum < 7'(NumRegs);
    assign reg_v  = regs[rnum[RegAw-1:0]];
    assign src    = r_rdata;

    always_comb begin
        res    = '0;
        wr_reg = 1'b1;
        case (opc)
            OP_LOAD: res = src;
            OP_IMM:  res = (part == 2'd1) ? {r_op[7:0], 8'h00} : r_op;
            OP_ADDM: res = (reg_v & m) + (src & m);
            OP_ADDI: res = (reg_v & m) + (r_op & m);
            OP_SUBM: res = (reg_v & m) - (src & m);
            OP_SUBI: res = (reg_v & m) - (r_op & m);
            OP_AND:  res = reg_v & src;
            OP_OR:   res = reg_v | src;
            OP_XOR:  res = reg_v ^ src;
            OP_NOT:  res = ~src;
            OP_SHL:  res = (r_op < 16'd16) ? ((reg_v & m) << r_op[3:0]) : 16'h0;
            OP_SHR:  res = (r_op < 16'd16) ? ((reg_v & m) >> r_op[3:0]) : 16'h0;
            default: wr_reg = 1'b0;
        endcase
        nv = (reg_v & ~m) | (res & m);
    end

    assign fg   = r_chreg[7:4];
    assign bg   = r_chreg[3:0];
    assign line = glyph_row(r_chreg[15:8], r_chcnt[3:2]);
    assign nib  = 4'(line >> (4'd12 - {r_chcnt[1:0], 2'b00}));
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pix[4*i +: 4] = nib[i] ? fg : bg;
        end
    end

    always_comb begin
        case (i_cmd.addr_sel)
            MA_IN:   maddr = i_in.address;
            MA_IP:   maddr = r_ip;
            MA_IP1:  maddr = r_ip + 16'd1;
            MA_OP:   maddr = r_op;
            MA_CH:   maddr = r_chdst + ((r_chcnt[1:0] == 2'd0) ? 16'h0000 :
                             (r_chcnt[1:0] == 2'd1) ? 16'h0001 :
                             (r_chcnt[1:0] == 2'd2) ? 16'h003C : 16'h003D);
            default: maddr = r_ip;
        endcase
        if (i_cmd.start) begin
            wdata = i_in.data;
        end else if (i_cmd.ch_step) begin
            wdata = pix;
        end else begin
            wdata = (src & ~m) | (reg_v & m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && (i_cmd.addr_sel != MA_OP || reg_ok)) begin
            mem[maddr[MemAw-1:0]] <= wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[maddr[MemAw-1:0]];
        end
    end

    assign o_sts.opcode   = opc;
    assign o_sts.ch_valid = sel < 8'(NumRegs);
    assign o_sts.ch_last  = r_chcnt == 4'hF;
    assign o_sts.halted   = r_halt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind  <= i_in.kind;
        end
        if (i_cmd.ld_w0) begin
            r_w0 <= r_rdata;
        end
        if (i_cmd.ld_op) begin
            r_op <= r_rdata;
        end
        if (i_cmd.ch_init) begin
            r_chreg <= regs[sel[RegAw-1:0]];
            r_chdst <= r_op;
            r_chcnt <= 4'd0;
        end else if (i_cmd.ch_step) begin
            r_chcnt <= r_chcnt + 4'd1;
            if (r_chcnt[1:0] == 2'd3) begin
                r_chdst <= r_chdst + 16'h0078;
            end
        end
        if (i_cmd.done) begin
            r_out.read_data    <= (r_kind == KIND_READ) ? r_rdata : 16'h0;
            r_out.next_ip      <= r_ip;
            r_out.zero_flag    <= r_zero;
            r_out.halted       <= r_halt;
            r_out.draw_request <= r_draw;
            r_out.bad_opcode   <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumRegs; i++) begin
                regs[i] <= '0;
            end
            r_ip   <= StartReset;
            r_zero <= 1'b0;
            r_halt <= 1'b0;
            r_draw <= 1'b0;
            r_bad  <= 1'b0;
        end else if (i_cfg_we) begin
            r_ip <= i_cfg_data;
        end else begin
            if (i_cmd.start) begin
                r_draw <= 1'b0;
                r_bad  <= 1'b0;
            end
            if (i_cmd.exec) begin
                if (opc >= OP_LOAD && opc <= OP_SHR) begin
                    r_ip <= r_ip + 16'd2;
                    if (reg_ok) begin
                        if (opc == OP_CMP) begin
                            r_zero <= (reg_v & m) == (r_op & m);
                        end else if (wr_reg) begin
                            regs[rnum[RegAw-1:0]] <= nv;
                            if (opc >= OP_ADDM) begin
                                r_zero <= (nv & m) == 16'h0;
                            end
                        end
                    end
                end else begin
                    case (opc)
                        OP_NOP:  r_ip <= r_ip + 16'd1;
                        OP_JMP:  r_ip <= r_op;
                        OP_JZ:   r_ip <= r_zero ? r_op : r_ip + 16'd2;
                        OP_JNZ:  r_ip <= !r_zero ? r_op : r_ip + 16'd2;
                        OP_CHAR: r_ip <= r_ip + 16'd2;
                        OP_DRAW: begin
                            r_draw <= 1'b1;
                            r_ip   <= r_ip + 16'd1;
                        end
                        OP_HALT: r_halt <= 1'b1;
                        default: begin
                            r_bad <= 1'b1;
                            r_ip  <= r_ip + 16'd1;
                        end
                    endcase
                end
            end
        end
    end

    assign o_out = r_out;

endmodule

// File: rtl/toy_cpu_instruction_step_core.sv
// Top level of the toy CPU step core: handshake ports, sequencer and datapath.
// One beat in gives one beat out. A memory write or read, an item of kind three, or an
// execute while halted goes from idle straight to the finish state; an instruction steps
// through W0, OP, SRC and EXE, as the single-port word memory is read in turn for the
// instruction word, operand and source word; CHAR adds CHR, writing all 16 glyph words.
// The start address register also reloads the instruction pointer when written.
module toy_cpu_instruction_step_core import tcis_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out
);

    t_cmd cmd;
    t_sts sts;

    tcis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_kind     (i_in.kind),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tcis_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (i_in),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_out     (o_out)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.start && cmd.done)) else $error("start and done together");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.done |=> o_out_valid) else $error("result not shown");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> !o_in_ready) else $error("ready while busy");

endmodule
